// ===== hw/rtl/wsd_pkg.sv =====
package wsd_pkg;

  // Result kinds carried on the output channel
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_TRUNC   = 2'd2
  } kind_t;

  // Short length field codes and mask
  localparam logic [6:0] LEN7_MASK  = 7'h7F;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Extended length byte counts, minus one
  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;

  // Key byte index of the final key byte
  localparam logic [1:0] KEY_LAST = 2'd3;

  // One result item
  typedef struct packed {
    kind_t       result_kind;
    logic        fin_bit;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic        is_masked;
    logic [63:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_in_frame;
  } result_t;

  // Result with its valid flag, parser to output stage
  typedef struct packed {
    logic    valid;
    result_t res;
  } result_req_t;

endpackage

// ===== hw/rtl/wsd_if.sv =====
// Byte input channel
interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// Result output channel
interface wsd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic        fin_bit;
  logic [2:0]  reserved_bits;
  logic [3:0]  frame_opcode;
  logic        is_masked;
  logic [63:0] payload_length;
  logic [7:0]  payload_byte;
  logic        last_in_frame;

  modport source (output valid, output result_kind, output fin_bit, output reserved_bits,
                  output frame_opcode, output is_masked, output payload_length,
                  output payload_byte, output last_in_frame, input ready);
  modport sink   (input valid, input result_kind, input fin_bit, input reserved_bits,
                  input frame_opcode, input is_masked, input payload_length,
                  input payload_byte, input last_in_frame, output ready);
endinterface

// ===== hw/rtl/wsd_parser.sv =====
module wsd_parser #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 frame_start,
  output wsd_pkg::result_req_t req
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEN  = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  phase_t                  phase, phase_next;
  logic [8:0]              flags, flags_next;
  logic [LENGTH_WIDTH-1:0] len, len_next;
  logic [2:0]              ext_cnt, ext_cnt_next;
  logic [31:0]             key, key_next;
  logic [1:0]              kidx, kidx_next;
  logic [LENGTH_WIDTH-1:0] remain, remain_next;

  logic                    len_done;
  logic                    hdr_done;
  logic [6:0]              len7;
  logic [7:0]              key_byte;

  // Key byte for the current payload byte, byte 0 in the top bits
  always_comb begin
    case (kidx)
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  assign len7 = data_byte[6:0] & wsd_pkg::LEN7_MASK;

  // Next state and result for the byte at the input
  always_comb begin
    phase_next  = phase;
    flags_next  = flags;
    len_next    = len;
    ext_cnt_next = ext_cnt;
    key_next    = key;
    kidx_next   = kidx;
    remain_next = remain;
    len_done    = 1'b0;
    hdr_done    = 1'b0;
    req         = '0;

    if (frame_start) begin
      // Start in mid-frame reports truncation, then begins the new frame
      if (phase != PH_IDLE) begin
        req.valid             = 1'b1;
        req.res.result_kind   = wsd_pkg::KIND_TRUNC;
        req.res.last_in_frame = 1'b1;
      end
      flags_next   = {1'b0, data_byte};
      len_next     = '0;
      ext_cnt_next = '0;
      key_next     = '0;
      kidx_next    = '0;
      remain_next  = '0;
      phase_next   = PH_LEN;
    end else begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_LEN: begin
          flags_next[8] = data_byte[7];
          len_next      = '0;
          if (len7 == wsd_pkg::LEN7_EXT16) begin
            ext_cnt_next = wsd_pkg::EXT16_LAST;
            phase_next   = PH_EXT;
          end else if (len7 == wsd_pkg::LEN7_EXT64) begin
            ext_cnt_next = wsd_pkg::EXT64_LAST;
            phase_next   = PH_EXT;
          end else begin
            len_next = LENGTH_WIDTH'(len7);
            len_done = 1'b1;
          end
        end
        PH_EXT: begin
          // Big-endian shift in, keeping the low LENGTH_WIDTH bits
          len_next = {len[LENGTH_WIDTH-9:0], data_byte};
          if (ext_cnt != 3'd0) begin
            ext_cnt_next = ext_cnt - 3'd1;
          end else begin
            len_done = 1'b1;
          end
        end
        PH_KEY: begin
          key_next = {key[23:0], data_byte};
          if (kidx != wsd_pkg::KEY_LAST) begin
            kidx_next = kidx + 2'd1;
          end else begin
            hdr_done = 1'b1;
          end
        end
        PH_DATA: begin
          req.valid              = 1'b1;
          req.res.result_kind    = wsd_pkg::KIND_PAYLOAD;
          req.res.payload_byte   = flags[8] ? (data_byte ^ key_byte) : data_byte;
          kidx_next              = kidx + 2'd1;
          remain_next            = remain - LENGTH_WIDTH'(1);
          if (remain == LENGTH_WIDTH'(1)) begin
            req.res.last_in_frame = 1'b1;
            phase_next            = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      // Length complete: fetch the key or close the header
      if (len_done) begin
        if (flags_next[8]) begin
          phase_next = PH_KEY;
          kidx_next  = '0;
          key_next   = '0;
        end else begin
          hdr_done = 1'b1;
        end
      end

      // Header complete: emit header result
      if (hdr_done) begin
        req.valid           = 1'b1;
        req.res.result_kind = wsd_pkg::KIND_HEADER;
        kidx_next           = '0;
        remain_next         = len_next;
        if (len_next == '0) begin
          req.res.last_in_frame = 1'b1;
          phase_next            = PH_IDLE;
        end else begin
          phase_next = PH_DATA;
        end
      end

      // Header and payload results carry the frame fields
      if (req.valid) begin
        req.res.fin_bit        = flags_next[7];
        req.res.reserved_bits  = flags_next[6:4];
        req.res.frame_opcode   = flags_next[3:0];
        req.res.is_masked      = flags_next[8];
        req.res.payload_length = 64'(len_next);
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      ext_cnt <= '0;
      kidx    <= '0;
      flags   <= '0;
      len     <= '0;
      key     <= '0;
      remain  <= '0;
    end else if (take) begin
      phase   <= phase_next;
      ext_cnt <= ext_cnt_next;
      kidx    <= kidx_next;
      flags   <= flags_next;
      len     <= len_next;
      key     <= key_next;
      remain  <= remain_next;
    end
  end

endmodule

// ===== hw/rtl/wsd_out_stage.sv =====
module wsd_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  wsd_pkg::result_req_t req,
  input  logic                 load,
  output logic                 can_take,
  output logic                 valid,
  input  logic                 ready,
  output wsd_pkg::result_t     res
);

  // Free when empty or when the held result transfers this cycle
  assign can_take = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_take) begin
      valid <= load && req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && load && req.valid) begin
      res <= req.res;
    end
  end

endmodule

// ===== hw/rtl/websocket_frame_deframer_core.sv =====
// A result is registered and presented in the cycle after the byte that causes it transfers.
// Throughput: one byte per cycle; the parser state updates in the accept cycle and
// the result register frees itself whenever the downstream side takes its result.
// Input stalls only while a held result is not taken.
// Reset (synchronous, active high) returns the parser to idle and empties the result register.
module websocket_frame_deframer_core #(
  parameter int LENGTH_WIDTH = 64
) (
  input logic         clk,
  input logic         rst,
  wsd_byte_if.sink    frame_bytes,
  wsd_result_if.source results
);

  wsd_pkg::result_req_t req;
  wsd_pkg::result_t     res;
  logic                 can_take;
  logic                 take;

  assign frame_bytes.ready = can_take;
  assign take              = frame_bytes.valid && can_take;

  // Header and payload parser
  wsd_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (frame_bytes.data_byte),
    .frame_start (frame_bytes.frame_start),
    .req         (req)
  );

  // Result register
  wsd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .load     (take),
    .can_take (can_take),
    .valid    (results.valid),
    .ready    (results.ready),
    .res      (res)
  );

  assign results.result_kind    = res.result_kind;
  assign results.fin_bit        = res.fin_bit;
  assign results.reserved_bits  = res.reserved_bits;
  assign results.frame_opcode   = res.frame_opcode;
  assign results.is_masked      = res.is_masked;
  assign results.payload_length = res.payload_length;
  assign results.payload_byte   = res.payload_byte;
  assign results.last_in_frame  = res.last_in_frame;

  // A stalled result blocks the input
  assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |-> !frame_bytes.ready)
    else $error("input taken while result stalled");

  // Truncation results are last and carry no length
  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.result_kind == wsd_pkg::KIND_TRUNC
      |-> results.last_in_frame && results.payload_length == 64'd0)
    else $error("malformed truncation result");

  // A header that closes its frame has zero length
  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.result_kind == wsd_pkg::KIND_HEADER && results.last_in_frame
      |-> results.payload_length == 64'd0)
    else $error("last header with nonzero length");

  // No result right after reset
  assert property (@(posedge clk) rst |=> !results.valid)
    else $error("result valid after reset");

endmodule

// ===== bench/wsd_checker.sv =====
module wsd_checker #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic  clk,
  input  logic  rst,
  wsd_byte_if   frame_bytes,
  wsd_result_if results,
  output int    fail_count,
  output int    pending,
  output int    headers_seen,
  output int    payloads_seen,
  output int    truncs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } phase_t;

  localparam logic [63:0] LEN_KEEP = {64{1'b1}} >> (64 - LENGTH_WIDTH);

  // Parser state, mirrored from the frame layout
  phase_t      phase;
  logic [8:0]  flags;      // byte one in 7..0, mask bit in 8
  logic [63:0] len_acc;
  logic [2:0]  ext_left;
  logic [31:0] key;
  logic [1:0]  key_idx;
  logic [63:0] remaining;

  wsd_pkg::result_t expected_q[$];

  // Frame fields common to header and payload results
  function automatic wsd_pkg::result_t frame_fields(input wsd_pkg::kind_t k);
    wsd_pkg::result_t f;
    f = '0;
    f.result_kind    = k;
    f.fin_bit        = flags[7];
    f.reserved_bits  = flags[6:4];
    f.frame_opcode   = flags[3:0];
    f.is_masked      = flags[8];
    f.payload_length = len_acc;
    return f;
  endfunction

  function automatic bit header_done(output wsd_pkg::result_t r);
    r         = frame_fields(wsd_pkg::KIND_HEADER);
    key_idx   = '0;
    remaining = len_acc;
    if (len_acc == '0) begin
      r.last_in_frame = 1'b1;
      phase           = PH_IDLE;
    end else begin
      phase = PH_DATA;
    end
    return 1'b1;
  endfunction

  // Length known: a masked frame still needs its key
  function automatic bit length_done(output wsd_pkg::result_t r);
    r = '0;
    if (flags[8]) begin
      phase   = PH_KEY;
      key_idx = '0;
      key     = '0;
      return 1'b0;
    end
    return header_done(r);
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic s,
                                     output wsd_pkg::result_t r);
    logic [7:0] kb;
    bit         cut;
    r = '0;
    if (s) begin
      cut = (phase != PH_IDLE);
      if (cut) begin
        r.result_kind   = wsd_pkg::KIND_TRUNC;
        r.last_in_frame = 1'b1;
      end
      flags     = {1'b0, b};
      len_acc   = '0;
      ext_left  = '0;
      key       = '0;
      key_idx   = '0;
      remaining = '0;
      phase     = PH_LEN;
      return cut;
    end
    case (phase)
      PH_LEN: begin
        flags[8] = b[7];
        len_acc  = '0;
        if ((b[6:0] & wsd_pkg::LEN7_MASK) == wsd_pkg::LEN7_EXT16) begin
          ext_left = wsd_pkg::EXT16_LAST;
          phase    = PH_EXT;
          return 1'b0;
        end
        if ((b[6:0] & wsd_pkg::LEN7_MASK) == wsd_pkg::LEN7_EXT64) begin
          ext_left = wsd_pkg::EXT64_LAST;
          phase    = PH_EXT;
          return 1'b0;
        end
        len_acc = {57'd0, b[6:0] & wsd_pkg::LEN7_MASK} & LEN_KEEP;
        return length_done(r);
      end
      PH_EXT: begin
        len_acc = {len_acc[55:0], b} & LEN_KEEP;
        if (ext_left != '0) begin
          ext_left = ext_left - 3'd1;
          return 1'b0;
        end
        return length_done(r);
      end
      PH_KEY: begin
        key = {key[23:0], b};
        if (key_idx != wsd_pkg::KEY_LAST) begin
          key_idx = key_idx + 2'd1;
          return 1'b0;
        end
        return header_done(r);
      end
      PH_DATA: begin
        kb                = flags[8] ? key[8 * (3 - int'(key_idx)) +: 8] : 8'h00;
        r                 = frame_fields(wsd_pkg::KIND_PAYLOAD);
        r.payload_byte    = b ^ kb;
        key_idx           = key_idx + 2'd1;
        remaining         = remaining - 64'd1;
        if (remaining == '0) begin
          r.last_in_frame = 1'b1;
          phase           = PH_IDLE;
        end
        return 1'b1;
      end
      default: begin
        phase = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic string show(input wsd_pkg::result_t r);
    return $sformatf("kind=%0d fin=%0b rsv=%0d op=%0h mask=%0b len=%016h byte=%02h last=%0b",
                     r.result_kind, r.fin_bit, r.reserved_bits, r.frame_opcode,
                     r.is_masked, r.payload_length, r.payload_byte, r.last_in_frame);
  endfunction

  // Compare result transfers, then predict from byte transfers
  always @(posedge clk) begin
    wsd_pkg::result_t got;
    wsd_pkg::result_t want;
    wsd_pkg::result_t fresh;
    if (rst) begin
      phase     = PH_IDLE;
      flags     = '0;
      len_acc   = '0;
      ext_left  = '0;
      key       = '0;
      key_idx   = '0;
      remaining = '0;
      expected_q.delete();
      fail_count    = 0;
      headers_seen  = 0;
      payloads_seen = 0;
      truncs_seen   = 0;
    end else begin
      if (results.valid && results.ready) begin
        got.result_kind    = wsd_pkg::kind_t'(results.result_kind);
        got.fin_bit        = results.fin_bit;
        got.reserved_bits  = results.reserved_bits;
        got.frame_opcode   = results.frame_opcode;
        got.is_masked      = results.is_masked;
        got.payload_length = results.payload_length;
        got.payload_byte   = results.payload_byte;
        got.last_in_frame  = results.last_in_frame;
        case (got.result_kind)
          wsd_pkg::KIND_HEADER:  headers_seen++;
          wsd_pkg::KIND_PAYLOAD: payloads_seen++;
          default:               truncs_seen++;
        endcase
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with nothing outstanding: %s", $realtime, show(got));
        end else begin
          want = expected_q.pop_front();
          if (got.result_kind !== want.result_kind || got.fin_bit !== want.fin_bit ||
              got.reserved_bits !== want.reserved_bits ||
              got.frame_opcode !== want.frame_opcode || got.is_masked !== want.is_masked ||
              got.payload_length !== want.payload_length ||
              got.payload_byte !== want.payload_byte ||
              got.last_in_frame !== want.last_in_frame) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      if (frame_bytes.valid && frame_bytes.ready) begin
        if (decode_byte(frame_bytes.data_byte, frame_bytes.frame_start, fresh))
          expected_q = {expected_q, fresh};
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== bench/tb_websocket_frame_deframer_core.sv =====
module tb_websocket_frame_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_W       = 64;
  localparam int DIRECTED    = 25;
  localparam int FRAME_ITEMS = 1550;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wsd_byte_if   frame_bytes();
  wsd_result_if results();

  int fail_count;
  int pending;
  int headers_seen;
  int payloads_seen;
  int truncs_seen;
  int bytes_sent;
  bit calm;      // no idling on either side while set
  bit drained;

  always #1 clk = ~clk;

  websocket_frame_deframer_core #(.LENGTH_WIDTH(LEN_W)) uut (
    .clk         (clk),
    .rst         (rst),
    .frame_bytes (frame_bytes),
    .results     (results)
  );

  wsd_checker #(.LENGTH_WIDTH(LEN_W)) checker_i (
    .clk           (clk),
    .rst           (rst),
    .frame_bytes   (frame_bytes),
    .results       (results),
    .fail_count    (fail_count),
    .pending       (pending),
    .headers_seen  (headers_seen),
    .payloads_seen (payloads_seen),
    .truncs_seen   (truncs_seen)
  );

  // Result side: random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      results.ready <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  // One byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic s);
    while (!calm && $urandom_range(0, 99) < 13) begin
      frame_bytes.valid <= 1'b0;
      @(posedge clk);
    end
    frame_bytes.valid       <= 1'b1;
    frame_bytes.data_byte   <= b;
    frame_bytes.frame_start <= s;
    @(posedge clk);
    while (!frame_bytes.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] fb[$]);
    foreach (fb[i]) send_byte(fb[i], i == 0);
  endtask

  // Hold off the sender until every outstanding result has arrived
  task automatic wait_drained();
    frame_bytes.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content; some cut short, some stray bytes
  task automatic send_random_frame();
    logic [7:0]  fb[$];
    logic [63:0] len;
    logic [31:0] mkey;
    logic        masked;
    int          pick;
    int          body;
    bit          broken;
    masked = 1'($urandom_range(0, 1));
    mkey   = $urandom;
    pick   = $urandom_range(0, 99);
    broken = ($urandom_range(0, 99) < 10);
    fb = {fb, 8'($urandom_range(0, 255))};
    if (pick < 55) begin
      len = 64'($urandom_range(0, 20));
      fb = {fb, {masked, len[6:0]}};
    end else if (pick < 70) begin
      len = 64'($urandom_range(21, 125));
      fb = {fb, {masked, len[6:0]}};
    end else if (pick < 85) begin
      len = (pick < 80) ? 64'($urandom_range(0, 200)) : 64'($urandom_range(0, 65535));
      fb = {fb, {masked, wsd_pkg::LEN7_EXT16}};
      fb = {fb, len[15:8]};
      fb = {fb, len[7:0]};
    end else begin
      len = (pick < 95) ? 64'($urandom_range(0, 150)) : {$urandom, $urandom};
      fb = {fb, {masked, wsd_pkg::LEN7_EXT64}};
      for (int i = 7; i >= 0; i--) fb = {fb, len[8 * i +: 8]};
    end
    if (masked)
      for (int i = 3; i >= 0; i--) fb = {fb, mkey[8 * i +: 8]};
    // long lengths only get a few bytes; the next frame start cuts them off
    body = (len > 64'd300) ? $urandom_range(0, 8) : int'(len);
    for (int i = 0; i < body; i++) fb = {fb, 8'($urandom_range(0, 255))};
    if (broken && fb.size() > 1) fb = fb[0:$urandom_range(0, fb.size() - 2)];
    send_frame(fb);
    if ($urandom_range(0, 99) < 5) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    logic [7:0] fb[$];
    frame_bytes.valid       <= 1'b0;
    frame_bytes.data_byte   <= 8'h00;
    frame_bytes.frame_start <= 1'b0;
    calm       = 1'b0;
    drained    = 1'b0;
    bytes_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stray byte while idle is dropped
    send_byte(8'hFF, 1'b0);
    // all header bits set, zero length: header is last
    fb = {8'hFF, 8'h00};
    send_frame(fb);
    // masked, 16-bit length of one, single payload byte
    fb = {8'h00, 8'hFE, 8'h00, 8'h01, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF};
    send_frame(fb);
    // 64-bit length of all ones, unmasked; cut off inside the payload
    fb = {8'h8A, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(fb);
    // masked frame cut off inside the key by the first random frame
    fb = {8'h09, 8'h85, 8'h11};
    send_frame(fb);

    while (bytes_sent < DIRECTED + FRAME_ITEMS) begin
      calm = (bytes_sent >= 600 && bytes_sent < 900);
      if (!drained && bytes_sent >= 1000) begin
        wait_drained();
        drained = 1'b1;
      end
      send_random_frame();
    end
    calm = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes: %0d headers, %0d payload bytes, %0d truncated frames checked",
             bytes_sent, headers_seen, payloads_seen, truncs_seen);
    $display("Mismatches: %0d, results still outstanding: %0d", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
